[rtl/tcpt_pkg.sv]
// Package for the three-channel prescaled timer unit
// Holds timer indexes, register indexes, widths and the target decode function
// No dependencies
package tcpt_pkg;

  // prescaler division ratio for the two slow timers
  localparam int unsigned PrescaleDiv = 8;
  localparam int unsigned PrescaleW   = 4;

  // timer geometry
  localparam int unsigned NumTimers = 3;
  localparam int unsigned StageW    = 9;
  localparam int unsigned OutCntW   = 4;

  // timer positions in the enable and fired masks
  localparam int unsigned TimerSlowA = 0;
  localparam int unsigned TimerSlowB = 1;
  localparam int unsigned TimerFast  = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgTimerEnable = 2'd0,
    CfgTargetSlowA = 2'd1,
    CfgTargetSlowB = 2'd2,
    CfgTargetFast  = 2'd3
  } cfg_idx_e;

  typedef logic [StageW-1:0]  stage_t;
  typedef logic [OutCntW-1:0] out_cnt_t;

  // reset value of a target register (256)
  localparam stage_t TargetReset = stage_t'(9'h100);

  // a target register value of zero stands for 256
  function automatic stage_t eff_target(input stage_t raw);
    stage_t res;
    res = (raw == '0) ? TargetReset : raw;
    return res;
  endfunction

endpackage

[rtl/three_channel_prescaled_timer_unit.sv]
// Top level of the three-channel prescaled timer unit
// Depends on tcpt_pkg for widths, indexes and the target decode
//
// Three interval timers: the fast timer steps on every tick, the two slow
// timers step when a shared prescaler wraps after eight ticks. Each enabled
// timer counts up to its target (register value 0 means 256), then clears
// and bumps its 4-bit wrapping output counter. One transaction is accepted
// per clock unless a stalled result blocks, a rate set by the single update
// of the timer state registers; its result is presented in the cycle after
// acceptance from an output register, and a new transaction is taken while
// the previous result waits as long as out_ready_i frees that register in
// the same cycle. Configuration writes take effect on the next clock.
module three_channel_prescaled_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_count_a_o,
  output logic [3:0]  out_count_b_o,
  output logic [3:0]  out_count_fast_o,
  output logic [2:0]  fired_mask_o
);

  localparam int unsigned NT = tcpt_pkg::NumTimers;

  // configuration registers
  logic [NT-1:0]        enable_q;
  tcpt_pkg::stage_t     target_q [NT];

  // timer state
  logic [tcpt_pkg::PrescaleW-1:0] prescale_q, prescale_d;
  tcpt_pkg::stage_t     stage_q  [NT];
  tcpt_pkg::stage_t     stage_d  [NT];
  tcpt_pkg::out_cnt_t   outcnt_q [NT];
  tcpt_pkg::out_cnt_t   outcnt_d [NT];
  logic [NT-1:0]        fired_d;

  // output register
  logic                 out_valid_q;
  tcpt_pkg::out_cnt_t   res_cnt_q [NT];
  logic [NT-1:0]        res_fired_q;

  logic                 accept;
  logic                 wrap;
  logic [NT-1:0]        step;
  logic [tcpt_pkg::PrescaleW:0] pre_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // prescaler next value and step strobes
  assign pre_inc = {1'b0, prescale_q} + 1'b1;
  assign wrap    = pre_inc >= (tcpt_pkg::PrescaleW + 1)'(tcpt_pkg::PrescaleDiv);

  always_comb begin
    prescale_d = prescale_q;
    if (tick_i) begin
      prescale_d = wrap ? '0 : pre_inc[tcpt_pkg::PrescaleW-1:0];
    end
    step = '0;
    step[tcpt_pkg::TimerFast]  = tick_i;
    step[tcpt_pkg::TimerSlowA] = tick_i && wrap;
    step[tcpt_pkg::TimerSlowB] = tick_i && wrap;
  end

  // per-timer count, compare and output counter update
  always_comb begin
    tcpt_pkg::stage_t nxt;
    for (int t = 0; t < NT; t++) begin
      nxt         = stage_q[t] + 1'b1;
      stage_d[t]  = stage_q[t];
      outcnt_d[t] = outcnt_q[t];
      fired_d[t]  = 1'b0;
      if (step[t] && enable_q[t]) begin
        if (nxt >= tcpt_pkg::eff_target(target_q[t])) begin
          stage_d[t]  = '0;
          outcnt_d[t] = outcnt_q[t] + 1'b1;
          fired_d[t]  = 1'b1;
        end else begin
          stage_d[t]  = nxt;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      for (int t = 0; t < NT; t++) begin
        target_q[t] <= tcpt_pkg::TargetReset;
      end
    end else if (cfg_we_i) begin
      case (tcpt_pkg::cfg_idx_e'(cfg_idx_i))
        tcpt_pkg::CfgTimerEnable: enable_q <= cfg_wdata_i[NT-1:0];
        tcpt_pkg::CfgTargetSlowA: target_q[tcpt_pkg::TimerSlowA] <= cfg_wdata_i;
        tcpt_pkg::CfgTargetSlowB: target_q[tcpt_pkg::TimerSlowB] <= cfg_wdata_i;
        tcpt_pkg::CfgTargetFast:  target_q[tcpt_pkg::TimerFast]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // timer state, updated on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      for (int t = 0; t < NT; t++) begin
        stage_q[t]  <= '0;
        outcnt_q[t] <= '0;
      end
    end else if (accept) begin
      prescale_q <= prescale_d;
      for (int t = 0; t < NT; t++) begin
        stage_q[t]  <= stage_d[t];
        outcnt_q[t] <= outcnt_d[t];
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int t = 0; t < NT; t++) begin
        res_cnt_q[t] <= outcnt_d[t];
      end
      res_fired_q <= fired_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_count_a_o    = res_cnt_q[tcpt_pkg::TimerSlowA];
  assign out_count_b_o    = res_cnt_q[tcpt_pkg::TimerSlowB];
  assign out_count_fast_o = res_cnt_q[tcpt_pkg::TimerFast];
  assign fired_mask_o     = res_fired_q;

`ifndef SYNTH
  // an idle transaction never reports a fired timer
  a_idle_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !tick_i) |=> (out_valid_o && fired_mask_o == '0))
    else $error("fired bit set on idle transaction");

  // slow timers fire only when the prescaler wraps
  a_slow_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !wrap) |=> (fired_mask_o[tcpt_pkg::TimerSlowA] == 1'b0 &&
                           fired_mask_o[tcpt_pkg::TimerSlowB] == 1'b0))
    else $error("slow timer fired without prescaler wrap");

  // prescaler stays below its division ratio
  a_prescale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prescale_q < tcpt_pkg::PrescaleW'(tcpt_pkg::PrescaleDiv))
    else $error("prescaler out of range");

  // a fired fast timer leaves its stage count at zero
  a_fast_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fired_d[tcpt_pkg::TimerFast]) |=> (stage_q[tcpt_pkg::TimerFast] == '0))
    else $error("fast stage count not cleared after firing");
`endif

endmodule

[sim/tb_three_channel_prescaled_timer_unit.sv]
// Self-checking testbench for the three-channel prescaled timer unit
// Depends on rtl/tcpt_pkg.sv and rtl/three_channel_prescaled_timer_unit.sv
// A scoreboard class predicts every result; plain tasks drive ticks and register writes
`timescale 1ns / 100ps

module tb_three_channel_prescaled_timer_unit;

  localparam int CycleLimit = 200000;

  // one result transaction as seen on the output channel
  typedef struct packed {
    tcpt_pkg::out_cnt_t cnt_a;
    tcpt_pkg::out_cnt_t cnt_b;
    tcpt_pkg::out_cnt_t cnt_fast;
    logic [2:0]         fired;
  } timer_result_t;

  // tracks timer state and holds the counter values still to come
  class timer_scoreboard;
    logic [2:0]         enable_q;
    tcpt_pkg::stage_t   target_q[tcpt_pkg::NumTimers];
    logic [3:0]         prescale_q;
    tcpt_pkg::stage_t   stage_q[tcpt_pkg::NumTimers];
    tcpt_pkg::out_cnt_t outcnt_q[tcpt_pkg::NumTimers];
    timer_result_t      predicted[$];
    int                 errors;
    int                 n_checked;
    int                 n_ticks;
    int                 n_idle;
    int                 fires[tcpt_pkg::NumTimers];

    function new();
      enable_q   = '0;
      prescale_q = '0;
      for (int i = 0; i < tcpt_pkg::NumTimers; i++) begin
        target_q[i] = tcpt_pkg::stage_t'(256);
        stage_q[i]  = '0;
        outcnt_q[i] = '0;
        fires[i]    = 0;
      end
      errors    = 0;
      n_checked = 0;
      n_ticks   = 0;
      n_idle    = 0;
    endfunction

    function void set_reg(tcpt_pkg::cfg_idx_e idx, logic [8:0] v);
      case (idx)
        tcpt_pkg::CfgTimerEnable: enable_q = v[2:0];
        tcpt_pkg::CfgTargetSlowA: target_q[tcpt_pkg::TimerSlowA] = v;
        tcpt_pkg::CfgTargetSlowB: target_q[tcpt_pkg::TimerSlowB] = v;
        tcpt_pkg::CfgTargetFast:  target_q[tcpt_pkg::TimerFast] = v;
        default: ;
      endcase
    endfunction

    // a zero target counts as 256
    function tcpt_pkg::stage_t target_limit(tcpt_pkg::stage_t raw);
      return (raw == '0) ? tcpt_pkg::stage_t'(256) : raw;
    endfunction

    // one step of timer t; returns its fired bit
    function bit step_timer(int unsigned t);
      tcpt_pkg::stage_t nxt;
      if (!enable_q[t]) return 1'b0;
      nxt = stage_q[t] + 1'b1;
      if (nxt >= target_limit(target_q[t])) begin
        stage_q[t]  = '0;
        outcnt_q[t] = outcnt_q[t] + 1'b1;
        fires[t]++;
        return 1'b1;
      end
      stage_q[t] = nxt;
      return 1'b0;
    endfunction

    // accepted input transaction: advance the timers and queue the result
    function void note_tick(logic tick);
      timer_result_t r;
      int            p;
      r.fired = '0;
      if (tick) begin
        n_ticks++;
        p = prescale_q + 1;
        r.fired[tcpt_pkg::TimerFast] = step_timer(tcpt_pkg::TimerFast);
        if (p >= tcpt_pkg::PrescaleDiv) begin
          prescale_q = '0;
          r.fired[tcpt_pkg::TimerSlowA] = step_timer(tcpt_pkg::TimerSlowA);
          r.fired[tcpt_pkg::TimerSlowB] = step_timer(tcpt_pkg::TimerSlowB);
        end else begin
          prescale_q = 4'(p);
        end
      end else begin
        n_idle++;
      end
      r.cnt_a    = outcnt_q[tcpt_pkg::TimerSlowA];
      r.cnt_b    = outcnt_q[tcpt_pkg::TimerSlowB];
      r.cnt_fast = outcnt_q[tcpt_pkg::TimerFast];
      predicted.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // accepted output transaction: compare with the oldest prediction
    task check_result(timer_result_t got);
      timer_result_t want;
      if (predicted.size() == 0) begin
        report($sformatf("result with nothing pending: a=%0d b=%0d fast=%0d fired=%b",
                         got.cnt_a, got.cnt_b, got.cnt_fast, got.fired));
        return;
      end
      want = predicted.pop_front();
      n_checked++;
      if (got.cnt_a !== want.cnt_a)
        report($sformatf("result %0d out_count_a got %0d want %0d",
                         n_checked, got.cnt_a, want.cnt_a));
      if (got.cnt_b !== want.cnt_b)
        report($sformatf("result %0d out_count_b got %0d want %0d",
                         n_checked, got.cnt_b, want.cnt_b));
      if (got.cnt_fast !== want.cnt_fast)
        report($sformatf("result %0d out_count_fast got %0d want %0d",
                         n_checked, got.cnt_fast, want.cnt_fast));
      if (got.fired !== want.fired)
        report($sformatf("result %0d fired_mask got %b want %b",
                         n_checked, got.fired, want.fired));
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [8:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       tick_i      = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] out_count_a_o;
  logic [3:0] out_count_b_o;
  logic [3:0] out_count_fast_o;
  logic [2:0] fired_mask_o;

  timer_scoreboard sb = new();
  bit quiet      = 1'b0;
  int stall_left = 0;
  int cycles     = 0;
  int n_settings = 0;

  three_channel_prescaled_timer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .tick_i           (tick_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_count_a_o    (out_count_a_o),
    .out_count_b_o    (out_count_b_o),
    .out_count_fast_o (out_count_fast_o),
    .fired_mask_o     (fired_mask_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL three_channel_prescaled_timer_unit");
      $finish;
    end
  end

  // receiver drops out_ready_i in random stall bursts
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // both channels sampled in one place so input and output order is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_tick(tick_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{out_count_a_o, out_count_b_o, out_count_fast_o, fired_mask_o});
    end
  end

  task automatic put_reg(tcpt_pkg::cfg_idx_e idx, logic [8:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // write the selected registers back to back, block must be idle
  task automatic apply_config(logic [3:0] sel, logic [8:0] en, logic [8:0] ta,
                              logic [8:0] tb, logic [8:0] tf);
    if (sel[tcpt_pkg::CfgTimerEnable]) put_reg(tcpt_pkg::CfgTimerEnable, en);
    if (sel[tcpt_pkg::CfgTargetSlowA]) put_reg(tcpt_pkg::CfgTargetSlowA, ta);
    if (sel[tcpt_pkg::CfgTargetSlowB]) put_reg(tcpt_pkg::CfgTargetSlowB, tb);
    if (sel[tcpt_pkg::CfgTargetFast])  put_reg(tcpt_pkg::CfgTargetFast, tf);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // one input transaction, with an optional idle burst in front
  task automatic push_item(logic t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic close_burst();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.predicted.size() != 0);
  endtask

  task automatic run_ticks(int n, int pct);
    repeat (n) push_item($urandom_range(0, 99) < pct);
    close_burst();
  endtask

  // mostly short targets so the output counters wrap, some extremes
  function automatic logic [8:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all timers off, idle and real ticks
    push_item(1'b0);
    push_item(1'b1);
    close_burst();

    // shortest targets, fast counter wraps, one idle item in the middle
    apply_config(4'hF, 9'd7, 9'd1, 9'd2, 9'd1);
    for (int i = 0; i < 18; i++) push_item(i != 9);
    close_burst();

    // fast timer alone with a zero target register
    apply_config(4'b1001, 9'd4, 9'd0, 9'd0, 9'd0);
    push_item(1'b1);
    push_item(1'b1);
    close_burst();

    // long run up to the largest fast target, enable written with high bits set
    apply_config(4'hF, 9'h1FF, 9'd3, 9'd1, 9'd511);
    run_ticks(560, 95);

    // targets lowered below the running counts
    apply_config(4'b1010, 9'd0, 9'd1, 9'd0, 9'd2);
    run_ticks(90, 85);

    // random settings
    repeat (5) begin
      apply_config(4'($urandom_range(1, 15)), 9'($urandom_range(0, 7)),
                   pick_target(), pick_target(), pick_target());
      run_ticks(90, $urandom_range(50, 100));
    end

    // closing stretch without idling on either side
    quiet = 1'b1;
    apply_config(4'hF, 9'd7, 9'($urandom_range(1, 4)), 9'($urandom_range(1, 4)),
                 9'($urandom_range(1, 6)));
    run_ticks(100, 90);

    repeat (4) @(posedge clk_i);
    $display("checked %0d results: %0d ticks, %0d idle items, %0d register settings",
             sb.n_checked, sb.n_ticks, sb.n_idle, n_settings);
    $display("timer fires: slow a %0d, slow b %0d, fast %0d",
             sb.fires[tcpt_pkg::TimerSlowA], sb.fires[tcpt_pkg::TimerSlowB],
             sb.fires[tcpt_pkg::TimerFast]);
    if (sb.errors == 0) begin
      $display("PASS three_channel_prescaled_timer_unit");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL three_channel_prescaled_timer_unit");
    end
    $finish;
  end

endmodule
